// ===== rtl/iws_pkg.sv =====
// Package: shared types and constants for the 1-D inverse wavelet synthesis core
`default_nettype none
package iws_pkg;

  localparam int MaxBand = 1024;
  localparam int MaxTaps = 32;
  localparam int SampleBits = 16;
  localparam int TapFraction = 14;
  localparam int BandAw = $clog2(MaxBand);
  localparam int TapAw = $clog2(MaxTaps);
  localparam int AccBits = SampleBits + 16 + 8;

  localparam logic [1:0] CMD_TAP = 2'd0;
  localparam logic [1:0] CMD_COEFF = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [2:0] REG_FLEN = 3'd0;
  localparam logic [2:0] REG_BLEN = 3'd1;
  localparam logic [2:0] REG_OLEN = 3'd2;
  localparam logic [2:0] REG_TRIM = 3'd3;
  localparam logic [2:0] REG_WRAP = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] tap_index;
    logic signed [15:0] low_tap;
    logic signed [15:0] high_tap;
    logic [9:0] coeff_index;
    logic signed [15:0] low_coeff;
    logic signed [15:0] high_coeff;
    logic [10:0] out_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [10:0] position;
    logic range_error;
  } out_item_t;

  // One classified job handed from front to back
  typedef struct packed {
    logic [10:0] position;
    logic range_error;
    logic phase;
    logic signed [12:0] first;
    logic [4:0] count;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/iws_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module iws_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/iws_front.sv =====
// Front end: accept items, do store writes, classify queries into jobs
`default_nettype none
module iws_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire iws_pkg::in_item_t   in_data,
  input  wire logic [5:0]          filter_length,
  input  wire logic [11:0]         output_length,
  input  wire logic [6:0]          trim_offset,
  output logic                     tap_we,
  output logic                     coeff_we,
  output logic                     job_push,
  output iws_pkg::job_t            job,
  input  wire logic                job_full,
  input  wire logic                store_busy
);
  logic       take;
  logic       is_write;
  logic [11:0] s;
  logic [5:0] flen;
  logic [5:0] cnt0;

  // Hold store writes while an earlier query is queued or being computed
  assign is_write = in_data.cmd == iws_pkg::CMD_TAP || in_data.cmd == iws_pkg::CMD_COEFF;
  assign in_ready = !job_full && !(store_busy && is_write);
  assign take = in_valid && in_ready;
  assign tap_we = take && in_data.cmd == iws_pkg::CMD_TAP;
  assign coeff_we = take && in_data.cmd == iws_pkg::CMD_COEFF;
  assign job_push = take && in_data.cmd == iws_pkg::CMD_COMPUTE;

  // Classify a query: phase, first index and tap count
  always_comb begin
    s = {1'b0, in_data.out_index} + {5'd0, trim_offset};
    flen = (filter_length > 6'(iws_pkg::MaxTaps)) ? 6'(iws_pkg::MaxTaps) : filter_length;
    cnt0 = s[0] ? {1'b0, flen[5:1]} : 6'((7'(flen) + 7'd1) >> 1);
    job.position = in_data.out_index;
    job.range_error = {1'b0, in_data.out_index} >= output_length;
    job.phase = s[0];
    job.first = {2'b00, s[11:1]};
    job.count = cnt0[4:0];
  end

  logic unused;
  assign unused = ^{clk, rst, cnt0[5]};
endmodule
`default_nettype wire

// ===== rtl/iws_back.sv =====
// Back end: multiply-accumulate over one phase of taps, round and saturate
`default_nettype none
module iws_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_valid,
  input  wire iws_pkg::job_t       job,
  output logic                     job_pop,
  output logic                     busy,
  input  wire logic [10:0]         band_length,
  input  wire logic                wrap_mode,
  output logic [4:0]               tap_raddr,
  output logic [9:0]               band_raddr,
  input  wire logic signed [15:0]  lo_tap,
  input  wire logic signed [15:0]  hi_tap,
  input  wire logic signed [15:0]  lo_coef,
  input  wire logic signed [15:0]  hi_coef,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output iws_pkg::out_item_t       out_data
);
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001, ST_ISSUE = 6'b000010, ST_MUL = 6'b000100,
    ST_ACC = 6'b001000, ST_DONE = 6'b010000, ST_MOD = 6'b100000
  } state_t;

  state_t state;
  iws_pkg::job_t cur;
  logic [4:0] j;
  logic signed [12:0] k;
  logic [10:0] n;
  logic [3:0] sh;
  logic [21:0] nsh;
  logic hit, hit_d;
  logic signed [31:0] plo, phi;
  logic signed [iws_pkg::AccBits-1:0] acc;
  logic signed [iws_pkg::AccBits-1:0] rnd;
  logic signed [iws_pkg::AccBits-1:0] q;
  logic signed [15:0] sat;
  logic [5:0] tidx;

  assign n = (band_length > 11'(iws_pkg::MaxBand)) ? 11'(iws_pkg::MaxBand) : band_length;
  assign nsh = 22'(n) << sh;
  assign tidx = {j, 1'b0} + {5'd0, cur.phase};
  assign tap_raddr = tidx[4:0];
  assign band_raddr = k[9:0];
  assign job_pop = (state == ST_IDLE) && job_valid && !out_valid;
  assign busy = state != ST_IDLE;
  assign plo = lo_tap * lo_coef;
  assign phi = hi_tap * hi_coef;

  // Round half up then saturate
  always_comb begin
    rnd = acc + (iws_pkg::AccBits)'(1 << (iws_pkg::TapFraction - 1));
    q = rnd >>> iws_pkg::TapFraction;
    if (q > 32767) sat = 16'sh7fff;
    else if (q < -32768) sat = -16'sh8000;
    else sat = q[15:0];
  end

  // Step through taps, one low and one high multiply per tap
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_pop) begin
            cur <= job;
            j <= '0;
            acc <= '0;
            k <= job.first;
            sh <= 4'd10;
            if (job.range_error || n == 0 || job.count == 0)
              state <= ST_DONE;
            else if (wrap_mode && $unsigned(job.first) >= 13'(n))
              state <= ST_MOD;
            else
              state <= ST_ISSUE;
          end
        end
        // Fold the start index into the band by shift and subtract
        ST_MOD: begin
          if ({9'd0, k} >= nsh) k <= k - 13'(nsh);
          sh <= sh - 4'd1;
          if (sh == 4'd0) state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          hit <= wrap_mode ? 1'b1 : (k >= 0 && k < 13'(n));
          state <= ST_MUL;
        end
        ST_MUL: begin
          hit_d <= hit && tidx < 6'(iws_pkg::MaxTaps);
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (hit_d) acc <= acc + (iws_pkg::AccBits)'(plo) + (iws_pkg::AccBits)'(phi);
          j <= j + 5'd1;
          k <= (wrap_mode && k == 0) ? 13'(n) - 13'sd1 : k - 13'sd1;
          state <= (j + 5'd1 == cur.count) ? ST_DONE : ST_ISSUE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.sample <= cur.range_error ? 16'sd0 :
                               (n == 0 || cur.count == 0) ? 16'sd0 : sat;
            out_data.position <= cur.position;
            out_data.range_error <= cur.range_error;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/inverse_wavelet_synthesis_1d_core.sv =====
// Top level: inverse wavelet synthesis core with front, job queue and MAC back end
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_ready   | in_data (iws_pkg::in_item_t)
//  out     | out | out_valid/out_ready | out_data (iws_pkg::out_item_t)
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// A query holds the back end for an issue, multiply and accumulate step per tap of
// its phase, plus a start and a result step; periodization may first have to fold
// the start index into the band by shift and subtract. A phase has at most 16 taps.
// The front drives store writes straight to the stores. Reset clears control state only.
// A two-entry job queue buffers queries; tap and coefficient writes wait until the
// queue is empty and the back end idle. A waiting result stops the next job.
`default_nettype none
module inverse_wavelet_synthesis_1d_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire iws_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output iws_pkg::out_item_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [11:0]         cfg_data
);
  logic [5:0] filter_length;
  logic [10:0] band_length;
  logic [11:0] output_length;
  logic [6:0] trim_offset;
  logic wrap_mode;
  logic tap_we, coeff_we, job_push, job_pop, job_full;
  logic job_valid, back_busy, store_busy;
  iws_pkg::job_t job_in, job_out;
  iws_pkg::job_t q0, q1;
  logic [1:0] qcnt;
  logic [4:0] tap_raddr;
  logic [9:0] band_raddr;
  logic [15:0] lo_tap, hi_tap, lo_coef, hi_coef;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_length <= 6'd2;
      band_length <= 11'd1;
      output_length <= 12'd2;
      trim_offset <= 7'd0;
      wrap_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        iws_pkg::REG_FLEN: filter_length <= cfg_data[5:0];
        iws_pkg::REG_BLEN: band_length <= cfg_data[10:0];
        iws_pkg::REG_OLEN: output_length <= cfg_data;
        iws_pkg::REG_TRIM: trim_offset <= cfg_data[6:0];
        iws_pkg::REG_WRAP: wrap_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign store_busy = job_valid || back_busy;

  iws_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .filter_length, .output_length, .trim_offset,
    .tap_we, .coeff_we, .job_push, .job(job_in), .job_full, .store_busy
  );

  // Two-entry job queue
  assign job_full = qcnt == 2'd2;
  assign job_valid = qcnt != 2'd0;
  assign job_out = q0;
  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0;
    end else begin
      case ({job_push, job_pop})
        2'b10: begin
          if (qcnt == 2'd0) q0 <= job_in; else q1 <= job_in;
          qcnt <= qcnt + 2'd1;
        end
        2'b01: begin
          q0 <= q1;
          qcnt <= qcnt - 2'd1;
        end
        2'b11: begin
          if (qcnt == 2'd1) q0 <= job_in; else begin q0 <= q1; q1 <= job_in; end
        end
        default: ;
      endcase
    end
  end

  iws_ram #(.Width(16), .Depth(iws_pkg::MaxTaps)) u_lo_tap (
    .clk, .we(tap_we), .waddr(in_data.tap_index), .wdata(in_data.low_tap),
    .raddr(tap_raddr), .rdata(lo_tap));
  iws_ram #(.Width(16), .Depth(iws_pkg::MaxTaps)) u_hi_tap (
    .clk, .we(tap_we), .waddr(in_data.tap_index), .wdata(in_data.high_tap),
    .raddr(tap_raddr), .rdata(hi_tap));
  iws_ram #(.Width(16), .Depth(iws_pkg::MaxBand)) u_lo_band (
    .clk, .we(coeff_we), .waddr(in_data.coeff_index), .wdata(in_data.low_coeff),
    .raddr(band_raddr), .rdata(lo_coef));
  iws_ram #(.Width(16), .Depth(iws_pkg::MaxBand)) u_hi_band (
    .clk, .we(coeff_we), .waddr(in_data.coeff_index), .wdata(in_data.high_coeff),
    .raddr(band_raddr), .rdata(hi_coef));

  iws_back u_back (
    .clk, .rst, .job_valid, .job(job_out), .job_pop, .busy(back_busy),
    .band_length, .wrap_mode, .tap_raddr, .band_raddr,
    .lo_tap(signed'(lo_tap)), .hi_tap(signed'(hi_tap)),
    .lo_coef(signed'(lo_coef)), .hi_coef(signed'(hi_coef)),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

// ===== rtl/iws_checker.sv =====
// Checker: port-level properties of the synthesis core, bound to the top level
`default_nettype none
module iws_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire iws_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out dropped");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_error |-> out_data.sample == 16'sd0) else $error("err sample");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset valid");
endmodule

bind inverse_wavelet_synthesis_1d_core iws_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_data);
`default_nettype wire
